// ===== design/iss_pkg.sv =====
// ----------------------------------------------------------------------------
// iss_pkg
// Shared request codes, status codes and controller states of the indexed
// sequence store.
// ----------------------------------------------------------------------------
package iss_pkg;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_APPEND = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PLACE,
    S_REPLY
  } state_t;

endpackage

// ===== design/iss_store.sv =====
// ----------------------------------------------------------------------------
// iss_store
// Element memory with one write port and one registered read port. A write
// either stores a new value or moves the word read in the previous cycle.
// ----------------------------------------------------------------------------
module iss_store #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32,
  parameter int ADDR_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic                  shift,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [VALUE_BITS-1:0] rdata
);

  logic [VALUE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= shift ? rdata : wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/indexed_sequence_store.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered sequence of up to CAPACITY values held densely in one memory, with
// read, insert, append and delete requests by position.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ group: s_tuser carries the action, s_tdata the
// position and the value. Each request produces exactly one reply on the m_
// group holding the status, the value read and the length afterwards.
// One request is worked on at a time; s_tready is high while the controller
// is idle, including while the previous reply still waits in the output
// register.
// A read, an append or an insert at the tail moves no stored element. An
// insert or a delete at position p moves every later element one place per
// cycle through the single read and write port of the element memory.
// Refused requests go from idle straight to the reply state.
// Reset empties the sequence at once; the memory needs no clearing pass.
// When the receiver stalls, the reply is held in the output register and
// the next finished reply waits in the controller until the register frees.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // Fields from bit 0: position[15:0], value[47:16].
  input  logic [47:0]      s_tdata,
  // Fields from bit 0: action[1:0].
  input  iss_pkg::action_t s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // Fields from bit 0: status[1:0], read_value[33:2], length_now[44:34], zero pad.
  output logic [47:0]      m_tdata
);

  import iss_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 16) ? CNT_W + 1 : 17;

  state_t                 state;
  state_t                 state_next;
  logic [CNT_W-1:0]       count;
  logic [AW-1:0]          wr_idx;
  logic [AW-1:0]          end_idx;
  logic [VALUE_BITS-1:0]  val_q;
  status_t                res_status;
  logic [31:0]            res_read;

  logic                   accept;
  logic                   out_free;
  logic                   pos_neg;
  logic [CMP_W-1:0]       pos_u;
  logic [CMP_W-1:0]       p_ins;
  logic [CMP_W-1:0]       cnt_ext;
  logic                   rw_bad;
  logic                   ins_bad;
  logic                   full;
  status_t                dec_status;
  logic signed [63:0]     val_wide;
  logic [VALUE_BITS-1:0]  new_value;
  logic signed [63:0]     rd_wide;

  logic                   mem_we;
  logic                   mem_shift;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_BITS-1:0]  mem_rdata;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign pos_neg   = s_tdata[15];
  assign pos_u     = CMP_W'(s_tdata[15:0]);
  assign p_ins     = pos_neg ? '0 : pos_u;
  assign cnt_ext   = CMP_W'(count);
  assign rw_bad    = pos_neg || (pos_u >= cnt_ext);
  assign ins_bad   = p_ins > cnt_ext;
  assign full      = count == CNT_W'(CAPACITY);
  assign val_wide  = 64'(signed'(s_tdata[47:16]));
  assign new_value = val_wide[VALUE_BITS-1:0];
  assign rd_wide   = 64'(signed'(mem_rdata));

  always_comb begin
    dec_status = ST_DONE;
    unique case (s_tuser)
      ACT_READ:   dec_status = rw_bad ? ST_RANGE : ST_DONE;
      ACT_INSERT: dec_status = ins_bad ? ST_RANGE : (full ? ST_FULL : ST_DONE);
      ACT_APPEND: dec_status = full ? ST_FULL : ST_DONE;
      ACT_DELETE: dec_status = rw_bad ? ST_RANGE : ST_DONE;
      default:    dec_status = ST_DONE;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (dec_status != ST_DONE) begin
            state_next = S_REPLY;
          end else begin
            unique case (s_tuser)
              ACT_READ:   state_next = S_READ;
              ACT_INSERT: state_next = (p_ins == cnt_ext) ? S_PLACE : S_SHIFT_UP;
              ACT_APPEND: state_next = S_PLACE;
              ACT_DELETE: state_next = (pos_u == cnt_ext - CMP_W'(1)) ? S_REPLY : S_SHIFT_DN;
              default:    state_next = S_REPLY;
            endcase
          end
        end
      end
      S_READ:     state_next = S_REPLY;
      S_SHIFT_UP: state_next = (wr_idx == end_idx) ? S_PLACE : S_SHIFT_UP;
      S_SHIFT_DN: state_next = (wr_idx == end_idx) ? S_REPLY : S_SHIFT_DN;
      S_PLACE:    state_next = S_REPLY;
      S_REPLY:    state_next = out_free ? S_IDLE : S_REPLY;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_shift = 1'b0;
    mem_waddr = wr_idx;
    mem_raddr = wr_idx;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        unique case (s_tuser)
          ACT_INSERT: mem_raddr = AW'(count - CNT_W'(1));
          ACT_DELETE: mem_raddr = AW'(pos_u + CMP_W'(1));
          default:    mem_raddr = AW'(pos_u);
        endcase
      end
      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_shift = 1'b1;
        mem_raddr = wr_idx - AW'(2);
      end
      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_shift = 1'b1;
        mem_raddr = wr_idx + AW'(2);
      end
      S_PLACE: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && dec_status == ST_DONE) begin
        if (s_tuser == ACT_INSERT || s_tuser == ACT_APPEND) begin
          count <= count + CNT_W'(1);
        end else if (s_tuser == ACT_DELETE) begin
          count <= count - CNT_W'(1);
        end
      end
      if (state == S_REPLY && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_q      <= new_value;
      res_status <= dec_status;
      res_read   <= '0;
      if (s_tuser == ACT_DELETE) begin
        wr_idx  <= AW'(pos_u);
        end_idx <= AW'(count - CNT_W'(2));
      end else begin
        wr_idx  <= AW'(count);
        end_idx <= AW'(p_ins + CMP_W'(1));
      end
    end
    unique case (state)
      S_READ:     res_read <= rd_wide[31:0];
      S_SHIFT_UP: wr_idx <= wr_idx - AW'(1);
      S_SHIFT_DN: wr_idx <= wr_idx + AW'(1);
      default:    ;
    endcase
    if (state == S_REPLY && out_free) begin
      m_tdata <= {3'b000, 11'(count), res_read, res_status};
    end
  end

  iss_store #(
    .DEPTH      (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .ADDR_W     (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .shift (mem_shift),
    .waddr (mem_waddr),
    .wdata (val_q),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("Element count exceeds the capacity.");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == ACT_APPEND && full
    |=> state == S_REPLY && res_status == ST_FULL && $stable(count))
    else $error("Append into a full store was not dropped.");

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT_UP |-> wr_idx >= end_idx)
    else $error("Upward shift ran past its end position.");

  a_read_refused: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == ACT_READ && rw_bad
    |=> res_status == ST_RANGE && res_read == 32'd0)
    else $error("Out-of-range read did not report a range error.");

  a_reply_issue: assert property (@(posedge clk) disable iff (rst)
    state == S_REPLY && out_free |=> m_tvalid && state == S_IDLE)
    else $error("Finished request was not moved to the output register.");

endmodule

// ===== bench/iss_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iss_checker
// Watches the request and reply streams of the indexed sequence store, keeps
// its own copy of the stored sequence, works out the reply due for every
// accepted request and compares each reply, field by field, in order.
// ----------------------------------------------------------------------------
module iss_checker #(
  parameter int CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  // Fields from bit 0: position[15:0], value[47:16].
  input  logic [47:0]      s_tdata,
  // Fields from bit 0: action[1:0].
  input  iss_pkg::action_t s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  // Fields from bit 0: status[1:0], read_value[33:2], length_now[44:34], zero pad.
  input  logic [47:0]      m_tdata,
  output int               failures,
  output int               pending,
  output int               seq_len
);

  import iss_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [10:0] length_now;
  } reply_t;

  reply_t      replies_due[$];
  reply_t      want;
  logic [31:0] seq_model [CAPACITY];
  int          replies_seen;

  task automatic log_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    failures++;
  endtask

  function automatic reply_t apply_request(input action_t act,
                                           input logic signed [15:0] pos,
                                           input logic [31:0] val);
    reply_t r;
    int     p;
    int     i;
    r.status     = ST_DONE;
    r.read_value = '0;
    p            = pos;
    case (act) inside
      ACT_READ: begin
        if (p < 0 || p >= seq_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = seq_model[p];
        end
      end
      ACT_INSERT, ACT_APPEND: begin
        if (act == ACT_APPEND) begin
          p = seq_len;
        end else if (p < 0) begin
          p = 0;
        end
        if (p > seq_len) begin
          r.status = ST_RANGE;
        end else if (seq_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = seq_len; i > p; i--) seq_model[i] = seq_model[i - 1];
          seq_model[p] = val;
          seq_len++;
        end
      end
      ACT_DELETE: begin
        if (p < 0 || p >= seq_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p; i < seq_len - 1; i++) seq_model[i] = seq_model[i + 1];
          seq_len--;
        end
      end
      default: begin
        r.status = ST_DONE;
      end
    endcase
    r.length_now = seq_len[10:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      replies_due.delete();
      seq_len      = 0;
      pending      = 0;
      failures     = 0;
      replies_seen = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          log_mismatch($sformatf("reply %0d arrived with no request outstanding",
                                 replies_seen));
        end else begin
          want = replies_due.pop_front();
          if (m_tdata[1:0] !== want.status)
            log_mismatch($sformatf("reply %0d: status %0d, expected %0d",
                                   replies_seen, m_tdata[1:0], want.status));
          if (m_tdata[33:2] !== want.read_value)
            log_mismatch($sformatf("reply %0d: read_value %h, expected %h",
                                   replies_seen, m_tdata[33:2], want.read_value));
          if (m_tdata[44:34] !== want.length_now)
            log_mismatch($sformatf("reply %0d: length_now %0d, expected %0d",
                                   replies_seen, m_tdata[44:34], want.length_now));
        end
        replies_seen++;
      end
      if (s_tvalid && s_tready)
        replies_due.push_back(apply_request(s_tuser, s_tdata[15:0], s_tdata[47:16]));
      pending = replies_due.size();
    end
  end

endmodule

// ===== bench/tb_indexed_sequence_store.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_sequence_store
// Drives read, insert, append and delete requests into the indexed sequence
// store: a directed opening, a fill to capacity and back, then random traffic
// under several idling and stalling patterns, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_indexed_sequence_store;
  import iss_pkg::*;

  localparam int CAPACITY       = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 140;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  action_t     s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        req_taken;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          failures;
  int          pending;
  int          seq_len;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  indexed_sequence_store #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(32)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  iss_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .failures(failures),
    .pending (pending),
    .seq_len (seq_len)
  );

  always @(posedge clk) req_taken <= s_tvalid && s_tready;

  always @(negedge clk) m_tready = ($urandom_range(99) >= stall_pct);

  task automatic send_request(input action_t act, input int pos, input logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = {$urandom(), 16'($urandom())};
      s_tuser  = action_t'($urandom_range(3));
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {val, pos[15:0]};
    s_tuser  = act;
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic pause_sender;
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_request;
    int          len;
    int          pick;
    int          pos;
    action_t     act;
    logic [31:0] val;
    len  = seq_len;
    pick = $urandom_range(99);
    if (pick < 20) begin
      act = ACT_READ;
    end else if (pick < 45) begin
      act = ACT_INSERT;
    end else if (pick < 65) begin
      act = ACT_APPEND;
    end else begin
      act = ACT_DELETE;
    end
    // Steer the length back towards a short sequence so that shifts stay cheap.
    if (len > 48 && act inside {ACT_INSERT, ACT_APPEND} && $urandom_range(1) == 1)
      act = ACT_DELETE;
    if (len < 4 && act == ACT_DELETE && $urandom_range(1) == 1)
      act = ACT_INSERT;
    pick = $urandom_range(99);
    if (pick < 75) begin
      pos = $urandom_range(len, 0);
    end else if (pick < 85) begin
      pos = len + $urandom_range(2);
    end else if (pick < 92) begin
      pos = -int'($urandom_range(3, 1));
    end else begin
      pos = int'($urandom_range(16'hFFFF));
    end
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'hFFFF_FFFF;
        default: val = 32'h0000_0000;
      endcase
    end else begin
      val = $urandom();
    end
    send_request(act, pos, val);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_indexed_sequence_store failed");
    $finish;
  end

  initial begin
    int phase;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = ACT_READ;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty store, clamping, head, middle and tail positions, value extremes.
    send_request(ACT_READ,   0,      32'h0);
    send_request(ACT_DELETE, 0,      32'h0);
    send_request(ACT_INSERT, 1,      32'h5555_5555);
    send_request(ACT_INSERT, -32768, 32'h8000_0000);
    send_request(ACT_APPEND, 0,      32'h7FFF_FFFF);
    send_request(ACT_INSERT, 1,      32'hFFFF_FFFF);
    send_request(ACT_INSERT, 3,      32'h0000_0000);
    send_request(ACT_READ,   0,      32'h0);
    send_request(ACT_READ,   1,      32'h0);
    send_request(ACT_READ,   2,      32'h0);
    send_request(ACT_READ,   3,      32'h0);
    send_request(ACT_READ,   4,      32'h0);
    send_request(ACT_READ,   -1,     32'h0);
    send_request(ACT_READ,   32767,  32'h0);
    send_request(ACT_DELETE, -32768, 32'h0);
    send_request(ACT_DELETE, 32767,  32'h0);
    send_request(ACT_DELETE, 1,      32'h0);
    send_request(ACT_DELETE, 2,      32'h0);
    send_request(ACT_DELETE, 0,      32'h0);
    send_request(ACT_INSERT, 32767,  32'h1234_5678);
    send_request(ACT_APPEND, -1,     32'h0000_0001);
    send_request(ACT_READ,   0,      32'h0);
    pause_sender();

    // Fill to capacity, probe the full store, then shrink again from the tail.
    idle_pct  = 38;
    stall_pct = 38;
    while (seq_len < CAPACITY) send_request(ACT_APPEND, $urandom_range(16'hFFFF), $urandom());
    send_request(ACT_APPEND, 0,            32'h1234_5678);
    send_request(ACT_INSERT, 0,            32'h1234_5678);
    send_request(ACT_INSERT, -7,           32'h1234_5678);
    send_request(ACT_INSERT, CAPACITY,     32'h1234_5678);
    send_request(ACT_INSERT, CAPACITY + 1, 32'h1234_5678);
    send_request(ACT_READ,   CAPACITY - 1, 32'h0);
    send_request(ACT_READ,   CAPACITY,     32'h0);
    send_request(ACT_DELETE, 0,            32'h0);
    send_request(ACT_INSERT, 0,            32'h8000_0000);
    send_request(ACT_READ,   0,            32'h0);
    while (seq_len > 16) send_request(ACT_DELETE, seq_len - 1 - $urandom_range(3), $urandom());
    pause_sender();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct  = 38;
          stall_pct = 38;
        end
      endcase
      repeat (PHASE_ITEMS / 2) random_request();
      pause_sender();
      repeat (PHASE_ITEMS / 2) random_request();
      pause_sender();
    end

    repeat (16) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb_indexed_sequence_store passed");
    end else begin
      $display("tb_indexed_sequence_store failed");
    end
    $finish;
  end

endmodule
